[design/barycentric_pixel_weights_macros.svh]
// ---------------------------------------------------------------------------
// Barycentric pixel weights: assertion macros
// Concurrent assertion wrappers on the block's clock; BPW_ASSERT also uses its reset.
// ---------------------------------------------------------------------------
`ifndef BARYCENTRIC_PIXEL_WEIGHTS_MACROS_SVH
`define BARYCENTRIC_PIXEL_WEIGHTS_MACROS_SVH
`ifndef SYNTHESIS
`define BPW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BPW_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BPW_ASSERT(lbl, prop, msg)
`define BPW_ASSERT_ANY(lbl, prop, msg)
`endif
`endif

[design/bpw_pkg.sv]
// ---------------------------------------------------------------------------
// Barycentric pixel weights package
// Item types, fixed-point widths and arithmetic helpers.
// ---------------------------------------------------------------------------
package bpw_pkg;

  localparam int unsigned DiffW = 17;  // coordinate difference, 13.4
  localparam int unsigned ProdW = 34;  // product of two differences, .8
  localparam int unsigned NumW  = 35;  // numerator or denominator, .8
  localparam int unsigned MagW  = 34;  // magnitude of a numerator
  localparam int unsigned FracW = 16;  // fraction bits of a weight
  localparam int unsigned QuoW  = MagW + FracW;  // quotient bits, one per stage
  localparam int unsigned WsW   = QuoW + 2;      // signed rounded weight
  localparam int unsigned W2W   = WsW + 1;       // one minus both weights
  localparam int unsigned OutW  = 24;

  localparam logic signed [W2W-1:0] OneQ16 = W2W'(65536);
  localparam logic signed [OutW-1:0] WMax = {1'b0, {(OutW-1){1'b1}}};
  localparam logic signed [OutW-1:0] WMin = {1'b1, {(OutW-1){1'b0}}};

  typedef struct packed {
    logic signed [15:0] vertex0_x;
    logic signed [15:0] vertex0_y;
    logic signed [15:0] vertex1_x;
    logic signed [15:0] vertex1_y;
    logic signed [15:0] vertex2_x;
    logic signed [15:0] vertex2_y;
    logic [10:0]        point_x;
    logic [10:0]        point_y;
  } bpw_in_t;

  typedef struct packed {
    logic signed [OutW-1:0] weight0;
    logic signed [OutW-1:0] weight1;
    logic signed [OutW-1:0] weight2;
    logic                   inside_res;
    logic                   degenerate;
  } bpw_out_t;

  function automatic logic [MagW-1:0] mag_of(input logic signed [NumW-1:0] v);
    logic [NumW-1:0] neg;
    neg = -v;
    return v[NumW-1] ? neg[MagW-1:0] : v[MagW-1:0];
  endfunction

  function automatic logic signed [OutW-1:0] sat24(input logic signed [W2W-1:0] v);
    logic signed [W2W-1:0] hi;
    logic signed [W2W-1:0] lo;
    hi = W2W'(WMax);
    lo = {{(W2W-OutW){1'b1}}, WMin};
    if (v > hi) return WMax;
    if (v < lo) return WMin;
    return v[OutW-1:0];
  endfunction

endpackage

[design/barycentric_pixel_weights.sv]
// Throughput: one item per cycle while the output is not stalled; the
// long-division pipeline retires one quotient bit per stage, 50 stages, so
// every stage is a 35-bit subtract.
// A stall at the output freezes the whole pipeline; nothing is lost.
// Reset (rst_ni low, asynchronous) clears every valid bit; payload is not reset.
// ---------------------------------------------------------------------------
// Barycentric pixel weights
// Pipelined barycentric weights and inside test of a pixel in a triangle.
// ---------------------------------------------------------------------------
`include "barycentric_pixel_weights_macros.svh"

module barycentric_pixel_weights (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bpw_pkg::bpw_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bpw_pkg::bpw_out_t out_data_o
);
  import bpw_pkg::*;

  // The pipeline moves as one: it advances whenever the output register is
  // empty or its item is being taken. Valid bits travel with each stage.
  logic adv;
  logic out_vld_q;
  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  // Stage 1: coordinate differences relative to vertex 2, all in 13.4.
  logic                    s1_vld_q;
  logic signed [DiffW-1:0] dx0_q, dy0_q, dx1_q, dy1_q, dpx_q, dpy_q;
  logic signed [DiffW-1:0] x2_s, y2_s;

  assign x2_s = {in_data_i.vertex2_x[15], in_data_i.vertex2_x};
  assign y2_s = {in_data_i.vertex2_y[15], in_data_i.vertex2_y};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx0_q <= {in_data_i.vertex0_x[15], in_data_i.vertex0_x} - x2_s;
      dy0_q <= {in_data_i.vertex0_y[15], in_data_i.vertex0_y} - y2_s;
      dx1_q <= {in_data_i.vertex1_x[15], in_data_i.vertex1_x} - x2_s;
      dy1_q <= {in_data_i.vertex1_y[15], in_data_i.vertex1_y} - y2_s;
      // The pixel position is brought to 12.4 so all terms share one scale.
      dpx_q <= $signed({2'b00, in_data_i.point_x, 4'b0000}) - x2_s;
      dpy_q <= $signed({2'b00, in_data_i.point_y, 4'b0000}) - y2_s;
    end
  end

  // Stage 2: the six cross products.
  logic                   s2_vld_q;
  logic signed [ProdW-1:0] pd_a_q, pd_b_q, pn0_a_q, pn0_b_q, pn1_a_q, pn1_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pd_a_q  <= dx0_q * dy1_q;
      pd_b_q  <= dx1_q * dy0_q;
      pn0_a_q <= dpx_q * dy1_q;
      pn0_b_q <= dx1_q * dpy_q;
      pn1_a_q <= dx0_q * dpy_q;
      pn1_b_q <= dpx_q * dy0_q;
    end
  end

  // Stage 3: denominator and numerators, then sign and magnitude so that the
  // divider works on unsigned values. Its outputs form divider stage zero.
  logic signed [NumW-1:0] den_s, num0_s, num1_s;

  assign den_s  = {pd_a_q[ProdW-1], pd_a_q} - {pd_b_q[ProdW-1], pd_b_q};
  assign num0_s = {pn0_a_q[ProdW-1], pn0_a_q} - {pn0_b_q[ProdW-1], pn0_b_q};
  assign num1_s = {pn1_a_q[ProdW-1], pn1_a_q} - {pn1_b_q[ProdW-1], pn1_b_q};

  logic [QuoW:0]     dv_vld_q;
  logic [MagW-1:0]   dv_den_q  [QuoW+1];
  logic [MagW-1:0]   dv_rem0_q [QuoW+1];
  logic [MagW-1:0]   dv_rem1_q [QuoW+1];
  logic [QuoW-1:0]   dv_rq0_q  [QuoW+1];
  logic [QuoW-1:0]   dv_rq1_q  [QuoW+1];
  logic [QuoW:0]     dv_neg0_q;
  logic [QuoW:0]     dv_neg1_q;
  logic [QuoW:0]     dv_degen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q <= '0;
    end else if (adv) begin
      dv_vld_q <= {dv_vld_q[QuoW-1:0], s2_vld_q};
    end
  end

  // Restoring division, one quotient bit per stage. The dividend shifts out of
  // the top of rq into the partial remainder while quotient bits enter below.
  // A zero denominator just runs through; its weights are forced to zero later.
  logic [MagW:0]   trial0 [QuoW];
  logic [MagW:0]   trial1 [QuoW];
  logic [MagW:0]   diff0  [QuoW];
  logic [MagW:0]   diff1  [QuoW];
  logic [QuoW-1:0] take0, take1;

  always_comb begin
    for (int i = 0; i < QuoW; i++) begin
      trial0[i] = {dv_rem0_q[i], dv_rq0_q[i][QuoW-1]};
      trial1[i] = {dv_rem1_q[i], dv_rq1_q[i][QuoW-1]};
      diff0[i]  = trial0[i] - {1'b0, dv_den_q[i]};
      diff1[i]  = trial1[i] - {1'b0, dv_den_q[i]};
      take0[i]  = !diff0[i][MagW];
      take1[i]  = !diff1[i][MagW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_den_q[0]   <= mag_of(den_s);
      dv_rem0_q[0]  <= '0;
      dv_rem1_q[0]  <= '0;
      dv_rq0_q[0]   <= {mag_of(num0_s), {FracW{1'b0}}};
      dv_rq1_q[0]   <= {mag_of(num1_s), {FracW{1'b0}}};
      dv_neg0_q[0]  <= num0_s[NumW-1] ^ den_s[NumW-1];
      dv_neg1_q[0]  <= num1_s[NumW-1] ^ den_s[NumW-1];
      dv_degen_q[0] <= (den_s == '0);
      for (int i = 0; i < QuoW; i++) begin
        dv_den_q[i+1]   <= dv_den_q[i];
        dv_rem0_q[i+1]  <= take0[i] ? diff0[i][MagW-1:0] : trial0[i][MagW-1:0];
        dv_rem1_q[i+1]  <= take1[i] ? diff1[i][MagW-1:0] : trial1[i][MagW-1:0];
        dv_rq0_q[i+1]   <= {dv_rq0_q[i][QuoW-2:0], take0[i]};
        dv_rq1_q[i+1]   <= {dv_rq1_q[i][QuoW-2:0], take1[i]};
        dv_neg0_q[i+1]  <= dv_neg0_q[i];
        dv_neg1_q[i+1]  <= dv_neg1_q[i];
        dv_degen_q[i+1] <= dv_degen_q[i];
      end
    end
  end

  // Rounding stage: round to nearest with ties away from zero, which comes to
  // adding one when twice the remainder reaches the divisor; then apply sign.
  logic                   rd_vld_q;
  logic                   rd_degen_q;
  logic signed [WsW-1:0]  rd_w0_q, rd_w1_q;
  logic                   rnd0, rnd1;
  logic [WsW-1:0]         qm0, qm1;

  assign rnd0 = {dv_rem0_q[QuoW], 1'b0} >= {1'b0, dv_den_q[QuoW]};
  assign rnd1 = {dv_rem1_q[QuoW], 1'b0} >= {1'b0, dv_den_q[QuoW]};
  assign qm0  = {2'b00, dv_rq0_q[QuoW]} + WsW'(rnd0);
  assign qm1  = {2'b00, dv_rq1_q[QuoW]} + WsW'(rnd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else if (adv) begin
      rd_vld_q <= dv_vld_q[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rd_w0_q    <= dv_neg0_q[QuoW] ? -qm0 : qm0;
      rd_w1_q    <= dv_neg1_q[QuoW] ? -qm1 : qm1;
      rd_degen_q <= dv_degen_q[QuoW];
    end
  end

  // Output stage: third weight from the unsaturated pair, the inside test on
  // their signs, saturation, and the degenerate override.
  logic signed [W2W-1:0] w0_x, w1_x, w2_x;
  logic                  inside_d;
  bpw_out_t              out_d, out_q;

  assign w0_x     = {rd_w0_q[WsW-1], rd_w0_q};
  assign w1_x     = {rd_w1_q[WsW-1], rd_w1_q};
  assign w2_x     = OneQ16 - w0_x - w1_x;
  assign inside_d = !w0_x[W2W-1] && !w1_x[W2W-1] && !w2_x[W2W-1];

  always_comb begin
    if (rd_degen_q) begin
      out_d = '0;
      out_d.degenerate = 1'b1;
    end else begin
      out_d.weight0    = sat24(w0_x);
      out_d.weight1    = sat24(w1_x);
      out_d.weight2    = sat24(w2_x);
      out_d.inside_res = inside_d;
      out_d.degenerate = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `BPW_ASSERT(a_degen_zero, out_vld_q && out_q.degenerate |-> (out_q.weight0 == '0) && (out_q.weight1 == '0) && (out_q.weight2 == '0) && !out_q.inside_res, "degenerate item with non-zero weights")
  `BPW_ASSERT(a_inside_signs, out_vld_q && out_q.inside_res |-> !out_q.weight0[OutW-1] && !out_q.weight1[OutW-1] && !out_q.weight2[OutW-1], "inside item with a negative weight")
  `BPW_ASSERT(a_empty_ready, !out_vld_q |-> in_ready_o, "pipeline stalled with an empty output")
  `BPW_ASSERT_ANY(a_reset_empty, !rst_ni |=> !out_vld_q && (dv_vld_q == '0), "valid bits set after a reset cycle")
endmodule

[sim/tb_barycentric_pixel_weights.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Barycentric pixel weights testbench
// Drives triangles and pixels through the block under random idling on both
// channels and compares every result with a predicted weight set.
// ---------------------------------------------------------------------------
module tb_barycentric_pixel_weights;
  import bpw_pkg::*;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  bpw_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  bpw_out_t out_data_o;

  // Idling phases: sender idle percentage and receiver stall percentage.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_off_left = 0;
  int unsigned error_count = 0;

  bpw_in_t  pending_items[$];
  bpw_out_t expected_weights[$];

  barycentric_pixel_weights u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Rounded quotient (num * 2^16) / den, ties away from zero.
  function automatic longint round_quotient(input longint num, input longint den);
    longint a;
    longint b;
    longint q;
    a = (num < 0 ? -num : num) <<< 16;
    b = den < 0 ? -den : den;
    q = (2 * a + b) / (2 * b);
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic logic signed [23:0] clamp_weight(input longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic bpw_out_t predict_weights(input bpw_in_t it);
    longint   x0, y0, x1, y1, x2, y2, px, py, area, n0, n1, w0, w1, w2;
    bpw_out_t r;
    x0 = it.vertex0_x; y0 = it.vertex0_y;
    x1 = it.vertex1_x; y1 = it.vertex1_y;
    x2 = it.vertex2_x; y2 = it.vertex2_y;
    px = longint'(it.point_x) * 16;
    py = longint'(it.point_y) * 16;
    r = '0;
    area = (x0 - x2) * (y1 - y2) - (x1 - x2) * (y0 - y2);
    if (area == 0) begin
      r.degenerate = 1'b1;
    end else begin
      n0 = (px - x2) * (y1 - y2) - (x1 - x2) * (py - y2);
      n1 = (x0 - x2) * (py - y2) - (px - x2) * (y0 - y2);
      w0 = round_quotient(n0, area);
      w1 = round_quotient(n1, area);
      w2 = 65536 - w0 - w1;
      // The inside decision uses the unsaturated signs.
      r.inside_res = (w0 >= 0) && (w1 >= 0) && (w2 >= 0);
      r.weight0 = clamp_weight(w0);
      r.weight1 = clamp_weight(w1);
      r.weight2 = clamp_weight(w2);
    end
    return r;
  endfunction

  function automatic bpw_in_t make_item(input int ax, input int ay, input int bx,
                                        input int by, input int cx, input int cy,
                                        input int qx, input int qy);
    bpw_in_t it;
    it.vertex0_x = ax[15:0]; it.vertex0_y = ay[15:0];
    it.vertex1_x = bx[15:0]; it.vertex1_y = by[15:0];
    it.vertex2_x = cx[15:0]; it.vertex2_y = cy[15:0];
    it.point_x = qx[10:0];   it.point_y = qy[10:0];
    return it;
  endfunction

  // Mostly small on-screen triangles with nearby pixels, so that the inside
  // test goes both ways; the rest is full-range noise and degenerate shapes.
  function automatic bpw_in_t random_item();
    bpw_in_t it;
    int      kind;
    int      bx;
    int      by;
    kind = $urandom_range(0, 9);
    it = bpw_in_t'($bits(bpw_in_t)'({$urandom, $urandom, $urandom, $urandom}));
    if (kind < 6) begin
      bx = $urandom_range(0, 1500);
      by = $urandom_range(0, 1500);
      it = make_item((bx + $urandom_range(0, 200)) * 16 + $urandom_range(0, 15),
                     (by + $urandom_range(0, 200)) * 16 + $urandom_range(0, 15),
                     (bx + $urandom_range(0, 200)) * 16 + $urandom_range(0, 15),
                     (by + $urandom_range(0, 200)) * 16 + $urandom_range(0, 15),
                     (bx + $urandom_range(0, 200)) * 16 + $urandom_range(0, 15),
                     (by + $urandom_range(0, 200)) * 16 + $urandom_range(0, 15),
                     bx + $urandom_range(0, 220), by + $urandom_range(0, 220));
    end else if (kind == 6) begin
      // Collinear vertices give a zero area.
      it.vertex1_x = it.vertex0_x;
      it.vertex2_x = it.vertex0_x;
    end
    return it;
  endfunction

  // Driver: offers the head of the queue, holding it until accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_ready_o) begin
      // Hold the item until the block takes it.
    end else if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      in_valid_i <= 1'b1;
      in_data_i  <= pending_items.pop_front();
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Prediction on acceptance; the receiver decides its ready for next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      expected_weights.push_back(predict_weights(in_data_i));
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
      out_ready_i   <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: each result against the oldest expectation.
  always @(posedge clk_i) begin
    bpw_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_weights.size() == 0) begin
        error_count <= error_count + 1;
        $display("%0t: result with none expected, actual %h", $time, out_data_o);
      end else begin
        want = expected_weights.pop_front();
        if (want !== out_data_o) begin
          error_count <= error_count + 1;
          $display("%0t: mismatch expected w0=%h w1=%h w2=%h in=%b dg=%b", $time,
                   want.weight0, want.weight1, want.weight2, want.inside_res,
                   want.degenerate);
          $display("%0t:          actual   w0=%h w1=%h w2=%h in=%b dg=%b", $time,
                   out_data_o.weight0, out_data_o.weight1, out_data_o.weight2,
                   out_data_o.inside_res, out_data_o.degenerate);
        end
      end
    end
  end

  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input int unsigned count);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++)
      pending_items.push_back(random_item());
    while (pending_items.size() != 0 || in_valid_i)
      @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: unit triangle corners, inside, outside, both windings,
    // field extremes, degenerate shapes and saturating weights.
    pending_items.push_back(make_item(0, 0, 160, 0, 0, 160, 0, 0));
    pending_items.push_back(make_item(0, 0, 160, 0, 0, 160, 10, 0));
    pending_items.push_back(make_item(0, 0, 160, 0, 0, 160, 0, 10));
    pending_items.push_back(make_item(0, 0, 160, 0, 0, 160, 3, 3));
    pending_items.push_back(make_item(0, 0, 160, 0, 0, 160, 9, 9));
    pending_items.push_back(make_item(0, 0, 0, 160, 160, 0, 3, 3));
    pending_items.push_back(make_item(0, 0, 16, 0, 0, 16, 0, 0));
    pending_items.push_back(make_item(0, 0, 1, 0, 0, 1, 2047, 2047));
    pending_items.push_back(make_item(-32768, -32768, 32767, -32768, -32768, 32767,
                                      2047, 0));
    pending_items.push_back(make_item(32767, 32767, -32768, 32767, 32767, -32768,
                                      0, 2047));
    pending_items.push_back(make_item(-32768, 32767, 32767, 32767, -32768, -32768,
                                      1024, 1024));
    pending_items.push_back(make_item(5, 5, 5, 5, 5, 5, 1, 1));
    pending_items.push_back(make_item(0, 0, 32, 32, 64, 64, 7, 3));
    pending_items.push_back(make_item(0, 0, 1, 0, 0, 1, 0, 0));
    pending_items.push_back(make_item(0, 0, 1, 0, 0, 1, 1, 0));
    pending_items.push_back(make_item(0, 0, 480, 0, 0, 480, 2047, 2047));
    pending_items.push_back(make_item(-1, -1, -1, 0, 0, -1, 2047, 2047));
    pending_items.push_back(make_item(0, 0, 48, 0, 0, 48, 1, 1));
    pending_items.push_back(make_item(0, 0, 48, 0, 0, 48, 1, 2));
    run_phase(0, 0, 0);
    run_phase(0, 0, 300);
    run_phase(83, 0, 250);
    run_phase(0, 83, 250);
    // Long receiver hold-off while the sender keeps offering items.
    hold_off_left = 300;
    run_phase(8, 8, 200);
    run_phase(0, 0, 250);
    while (expected_weights.size() != 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (error_count == 0 && expected_weights.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #3ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[barycentric_pixel_weights.f]
+incdir+design
design/bpw_pkg.sv
design/barycentric_pixel_weights.sv
sim/tb_barycentric_pixel_weights.sv
